// ----- rtl/i2da_pkg.sv -----
package i2da_pkg;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

endpackage

// ----- rtl/integer_to_decimal_ascii.sv -----
// Channel   Dir  Handshake        tdata                         tuser / tlast
// s_*       in   tvalid/tready    value [VALUE_WIDTH-1:0]       tuser = mode
// m_*       out  tvalid/tready    character [7:0]               tlast = is_last
//
// An item is accepted while the block is idle, then converted by shift-add-3 over
// VALUE_WIDTH bits with one nibble adjust unit per decimal digit; leading zero digits
// are then skipped, keeping at least one digit, a minus sign is sent for a negative
// value, and then one character per cycle while the output side takes it.
// s_tready is high only while the block is idle. arst_n clears the sequencer at once.
// A stalled output holds its character until m_tready is seen high.
module integer_to_decimal_ascii
	import i2da_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// value
	input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// mode
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// character
	output logic [7:0]                           m_tdata,
	output logic                                 m_tlast
);

	localparam int NDIG  = ((VALUE_WIDTH * 1233) >> 12) + 1;
	localparam int BCD_W = NDIG * 4;
	localparam int CNT_W = $clog2(VALUE_WIDTH);
	localparam int REM_W = $clog2(NDIG + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [REM_W-1:0]       rem_q;
	logic                   neg_q;

	logic [VALUE_WIDTH-1:0] in_value;
	logic                   in_neg;
	logic [BCD_W-1:0]       bcd_adj;
	logic [3:0]             top_digit;

	assign in_value  = s_tdata[VALUE_WIDTH-1:0];
	assign in_neg    = s_tuser & in_value[VALUE_WIDTH-1];
	assign top_digit = bcd_q[BCD_W-1 -: 4];

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= BCD_ADJ_MIN) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + BCD_ADJ_ADD;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_SIGN) || (state_q == ST_EMIT);
	assign m_tdata  = (state_q == ST_SIGN) ? ASCII_MINUS : (ASCII_ZERO + {4'h0, top_digit});
	assign m_tlast  = (state_q == ST_EMIT) && (rem_q == REM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						neg_q   <= in_neg;
						bin_q   <= in_neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;
						bcd_q   <= '0;
						cnt_q   <= CNT_W'(VALUE_WIDTH - 1);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_WIDTH-1]};
					bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						rem_q   <= REM_W'(NDIG);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if ((top_digit == 4'h0) && (rem_q != REM_W'(1))) begin
						bcd_q <= {bcd_q[BCD_W-5:0], 4'h0};
						rem_q <= rem_q - REM_W'(1);
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (m_tready) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						if (rem_q == REM_W'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							bcd_q <= {bcd_q[BCD_W-5:0], 4'h0};
							rem_q <= rem_q - REM_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/i2da_checker.sv -----
module i2da_checker
	import i2da_pkg::*;
(
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	// character
	input logic [7:0]                           m_tdata,
	input logic                                 m_tlast
);

	// An idle block has no character pending.
	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> !m_tvalid)
		else $error("output valid while input side is ready");

	// Every character is a minus sign or a decimal digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == ASCII_MINUS) ||
			((m_tdata >= ASCII_ZERO) && (m_tdata <= ASCII_ZERO + 8'd9)))
		else $error("character out of range");

	// A minus sign is never the last character, and no zero directly follows it.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && (m_tdata == ASCII_MINUS) |-> !m_tlast ##1
			(m_tvalid && (m_tdata != ASCII_ZERO)))
		else $error("bad text after minus sign");

	// An accepted item keeps the input side closed in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	// A stalled character holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output changed");

endmodule

bind integer_to_decimal_ascii i2da_checker u_i2da_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
